>>> rtl/command_line_tokenizer_unit_assert.svh
// ============================================================================
// Assertion macros for the command line tokenizer
// Immediate-style wrappers around clocked concurrent assertions.
// ============================================================================
`ifndef COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLTOK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/cltok_pkg.sv
// ============================================================================
// Command line tokenizer package
// Shared constants, character codes and the action descriptor type.
// ============================================================================
package cltok_pkg;

    localparam int MAX_RUN     = 32;
    localparam int RUN_W       = $clog2(MAX_RUN + 1);
    // The queue pointers wrap naturally, so the depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_FORMAT = 2'd2
    } t_mode;

    // Everything one input character produces, in output order:
    // overflow flag, leading backslashes, two bytes, token end,
    // trailing backslashes, flushed held byte, final token end.
    typedef struct packed {
        logic             ovf;
        logic [RUN_W-1:0] nsl;
        logic             sl_after;
        logic             b0v;
        logic [7:0]       b0;
        logic             b1v;
        logic [7:0]       b1;
        logic             te0;
        logic             b2v;
        logic [7:0]       b2;
        logic             te1;
    } t_desc;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> rtl/cltok_if.sv
// ============================================================================
// Command line tokenizer channels
// Valid/ready channels for input characters and token results.
// ============================================================================
interface cltok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_command;

    modport source (output valid, in_byte, end_of_command, input ready);
    modport sink   (input valid, in_byte, end_of_command, output ready);
endinterface

interface cltok_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       token_end;
    logic       run_overflow;
    logic       last_of_run;

    modport source (output valid, out_byte, byte_valid, token_end, run_overflow,
                    last_of_run, input ready);
    modport sink   (input valid, out_byte, byte_valid, token_end, run_overflow,
                    last_of_run, output ready);
endinterface

>>> rtl/cltok_front.sv
// ============================================================================
// Command line tokenizer front end
// Accepts one character per cycle while the queue is not full, tracks the
// parse state and turns it into an action descriptor for the back end.
// ============================================================================
module cltok_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cltok_in_if.sink          i_in,
    input  cltok_pkg::t_q_stat i_q_stat,
    output logic              o_push,
    output cltok_pkg::t_desc  o_desc
);
    import cltok_pkg::*;

    typedef struct packed {
        t_mode            mode;
        logic [RUN_W-1:0] run;
        logic             held_v;
        logic [7:0]       held;
        logic             ftd;
        t_desc            desc;
    } t_work;

    t_mode            r_mode, n_mode;
    logic [RUN_W-1:0] r_run, n_run;
    logic             r_held_v, n_held_v;
    logic [7:0]       r_held, n_held;
    logic             r_ftd, n_ftd;
    t_work            w;
    logic             accept;
    logic             nonempty;

    function automatic t_work f_put(t_work a, logic [7:0] b);
        t_work r;
        r = a;
        if (!r.desc.b0v) begin
            r.desc.b0v = 1'b1;
            r.desc.b0  = b;
        end else begin
            r.desc.b1v = 1'b1;
            r.desc.b1  = b;
        end
        return r;
    endfunction

    function automatic t_work f_close(t_work a);
        t_work r;
        r = a;
        r.desc.te0 = 1'b1;
        r.ftd      = 1'b1;
        return r;
    endfunction

    function automatic t_work f_fresh_plain(t_work a, logic [7:0] c);
        t_work r;
        r = a;
        case (c) inside
            CH_TAB, CH_SPACE: begin
                if (!r.ftd) r = f_close(r);
            end
            CH_COMMA:  r = f_close(r);
            CH_BSLASH: r.run = RUN_W'(1);
            CH_QUOTE:  r.mode = MODE_QUOTED;
            default:   r = f_put(r, c);
        endcase
        return r;
    endfunction

    function automatic t_work f_fresh_quoted(t_work a, logic [7:0] c);
        t_work r;
        r = a;
        case (c) inside
            CH_BSLASH: r.run = RUN_W'(1);
            CH_QUOTE:  r.mode = MODE_PLAIN;
            CH_LBRACE: begin
                r.mode = MODE_FORMAT;
                r = f_put(r, c);
            end
            default:   r = f_put(r, c);
        endcase
        return r;
    endfunction

    function automatic t_work f_fresh_format(t_work a, logic [7:0] c);
        t_work r;
        r = a;
        if (c == CH_RBRACE || c == CH_BSLASH) begin
            r.held_v = 1'b1;
            r.held   = c;
        end else begin
            r = f_put(r, c);
        end
        return r;
    endfunction

    function automatic t_work f_fresh(t_work a, logic [7:0] c);
        t_work r;
        unique case (a.mode)
            MODE_QUOTED: r = f_fresh_quoted(a, c);
            MODE_FORMAT: r = f_fresh_format(a, c);
            default:     r = f_fresh_plain(a, c);
        endcase
        return r;
    endfunction

    // A backslash run closed by a non-backslash character in plain mode.
    function automatic t_work f_run_plain(t_work a, logic [RUN_W-1:0] n, logic [7:0] c);
        t_work r;
        r = a;
        if (c == CH_QUOTE) begin
            r.desc.nsl = n >> 1;
            if (n[0]) r = f_put(r, c);
            else      r.mode = MODE_QUOTED;
        end else begin
            r.desc.nsl = {n[RUN_W-1:1], 1'b0};
            if (!n[0]) begin
                r = f_fresh_plain(r, c);
            end else if (c == CH_SPACE || c == CH_TAB) begin
                r = f_put(r, CH_SPACE);
            end else if (c == CH_COMMA) begin
                r = f_put(r, c);
            end else begin
                r = f_put(r, CH_BSLASH);
                r = f_put(r, c);
            end
        end
        return r;
    endfunction

    function automatic t_work f_run_quoted(t_work a, logic [RUN_W-1:0] n, logic [7:0] c);
        t_work r;
        r = a;
        if (c == CH_LBRACE) begin
            r.desc.nsl = n >> 1;
            r = f_put(r, c);
            if (!n[0]) r.mode = MODE_FORMAT;
        end else if (c == CH_QUOTE) begin
            r.desc.nsl = n >> 1;
            if (n[0]) r = f_put(r, c);
            else      r.mode = MODE_PLAIN;
        end else begin
            r.desc.nsl = n;
            r = f_fresh_quoted(r, c);
        end
        return r;
    endfunction

    function automatic t_work f_take(t_work a, logic [7:0] c);
        t_work            r;
        logic [7:0]       h;
        logic [RUN_W-1:0] n;
        r = a;
        h = a.held;
        n = a.run;
        if (a.held_v) begin
            r.held_v = 1'b0;
            r.held   = '0;
            if (h == CH_RBRACE) begin
                r = f_put(r, h);
                if (c == CH_RBRACE) begin
                    r = f_put(r, c);
                end else begin
                    r.mode = MODE_QUOTED;
                    r = f_fresh_quoted(r, c);
                end
            end else if (c == CH_QUOTE || c == CH_BSLASH) begin
                r = f_put(r, c);
            end else begin
                r = f_put(r, h);
                r = f_fresh_format(r, c);
            end
        end else if (a.run != '0) begin
            if (c == CH_BSLASH) begin
                // Past the maximum the run saturates and only the flag goes out.
                if (a.run < RUN_W'(MAX_RUN)) r.run = a.run + RUN_W'(1);
                else                         r.desc.ovf = 1'b1;
            end else begin
                r.run = '0;
                if (a.mode == MODE_QUOTED) r = f_run_quoted(r, n, c);
                else                       r = f_run_plain(r, n, c);
            end
        end else begin
            r = f_fresh(r, c);
        end
        return r;
    endfunction

    always_comb begin
        w.mode   = r_mode;
        w.run    = r_run;
        w.held_v = r_held_v;
        w.held   = r_held;
        w.ftd    = r_ftd;
        w.desc   = '0;
        w = f_take(w, i_in.in_byte);
        if (i_in.end_of_command) begin
            // Flush whatever is pending, close the token and start over.
            if (w.run != '0) begin
                w.desc.nsl      = w.run;
                w.desc.sl_after = 1'b1;
            end
            if (w.held_v) begin
                w.desc.b2v = 1'b1;
                w.desc.b2  = w.held;
            end
            w.desc.te1 = 1'b1;
            w.mode     = MODE_PLAIN;
            w.run      = '0;
            w.held_v   = 1'b0;
            w.held     = '0;
            w.ftd      = 1'b0;
        end
        n_mode   = w.mode;
        n_run    = w.run;
        n_held_v = w.held_v;
        n_held   = w.held;
        n_ftd    = w.ftd;
    end

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign nonempty   = w.desc.ovf || (w.desc.nsl != '0) || w.desc.b0v || w.desc.b1v ||
                        w.desc.te0 || w.desc.b2v || w.desc.te1;
    assign o_push     = accept && nonempty;
    assign o_desc     = w.desc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_run    <= '0;
            r_held_v <= 1'b0;
            r_held   <= '0;
            r_ftd    <= 1'b0;
        end else if (accept) begin
            r_mode   <= n_mode;
            r_run    <= n_run;
            r_held_v <= n_held_v;
            r_held   <= n_held;
            r_ftd    <= n_ftd;
        end
    end

endmodule

>>> rtl/cltok_queue.sv
// ============================================================================
// Command line tokenizer descriptor queue
// Short FIFO of action descriptors between the front and back ends.
// ============================================================================
module cltok_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  cltok_pkg::t_desc   i_desc,
    input  logic               i_pop,
    output cltok_pkg::t_desc   o_head,
    output cltok_pkg::t_q_stat o_q_stat
);
    import cltok_pkg::*;

    t_desc             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    always_comb begin
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            if (i_pop)  r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            r_count <= n_count;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_q_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_q_stat.empty = (r_count == '0);

endmodule

>>> rtl/cltok_back.sv
// ============================================================================
// Command line tokenizer back end
// Expands each action descriptor into result transactions, one per cycle
// while the receiver keeps up, through a registered output stage.
// ============================================================================
module cltok_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cltok_pkg::t_desc   i_head,
    input  cltok_pkg::t_q_stat i_q_stat,
    output logic               o_pop,
    cltok_out_if.source        o_out
);
    import cltok_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       data_vld;
        logic       tok_end;
        logic       ovf;
        logic       last;
    } t_res;

    t_desc r_cur, n_cur;
    logic  r_cur_vld, n_cur_vld;
    t_res  r_out;
    logic  r_out_vld;
    t_desc rem;
    t_res  res;
    logic  last;
    logic  adv;
    logic  fire;

    always_comb begin
        rem = r_cur;
        res = '0;
        // Pick the first outstanding part of the descriptor and retire it.
        if (r_cur.ovf) begin
            res.ovf = 1'b1;
            rem.ovf = 1'b0;
        end else if (r_cur.nsl != '0 && !r_cur.sl_after) begin
            res.data_vld = 1'b1;
            res.data     = CH_BSLASH;
            rem.nsl      = r_cur.nsl - RUN_W'(1);
        end else if (r_cur.b0v) begin
            res.data_vld = 1'b1;
            res.data     = r_cur.b0;
            rem.b0v      = 1'b0;
        end else if (r_cur.b1v) begin
            res.data_vld = 1'b1;
            res.data     = r_cur.b1;
            rem.b1v      = 1'b0;
        end else if (r_cur.te0) begin
            res.tok_end = 1'b1;
            rem.te0     = 1'b0;
        end else if (r_cur.nsl != '0) begin
            res.data_vld = 1'b1;
            res.data     = CH_BSLASH;
            rem.nsl      = r_cur.nsl - RUN_W'(1);
        end else if (r_cur.b2v) begin
            res.data_vld = 1'b1;
            res.data     = r_cur.b2;
            rem.b2v      = 1'b0;
        end else begin
            res.tok_end = 1'b1;
            rem.te1     = 1'b0;
        end
        last = !(rem.ovf || rem.b0v || rem.b1v || rem.te0 || rem.b2v || rem.te1) &&
               (rem.nsl == '0);
        res.last = last;

        adv   = !r_out_vld || o_out.ready;
        fire  = r_cur_vld && adv;
        o_pop = !i_q_stat.empty && (!r_cur_vld || (fire && last));

        if (o_pop) begin
            n_cur     = i_head;
            n_cur_vld = 1'b1;
        end else if (fire) begin
            n_cur     = rem;
            n_cur_vld = !last;
        end else begin
            n_cur     = r_cur;
            n_cur_vld = r_cur_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (adv) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cur_vld <= n_cur_vld;
            if (adv) r_out_vld <= fire;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.out_byte     = r_out.data;
    assign o_out.byte_valid   = r_out.data_vld;
    assign o_out.token_end    = r_out.tok_end;
    assign o_out.run_overflow = r_out.ovf;
    assign o_out.last_of_run  = r_out.last;

endmodule

>>> rtl/command_line_tokenizer_unit.sv
// ============================================================================
// Command line tokenizer
// Splits a command string into tokens, honoring quotes, braces and
// backslash runs, and streams token bytes and token-end marks.
// ============================================================================
// Usage: characters enter on i_in (valid/ready), one per transaction, with
// end_of_command set on the last character of a command. Results leave on
// o_out (valid/ready): a token byte, a token end, or a run overflow flag,
// with last_of_run set on the final result that a character produces.
// A character's first result passes the descriptor queue, the current
// descriptor and the output register. Throughput: one character per cycle
// while each yields at most one result and o_out is not stalled; one with
// more results keeps the expander busy until all have gone, the longest case
// being a saturated backslash run flushed at the end of a command. A
// four-entry queue absorbs such bursts; i_in.ready drops only when it is full.
// Reset returns the parser to plain mode and empties the queue and the
// output register. When the receiver stalls, the held result stays on
// o_out and characters keep entering until the queue fills.
module command_line_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cltok_in_if.sink    i_in,
    cltok_out_if.source o_out
);
    import cltok_pkg::*;

    t_desc   w_desc;
    t_desc   w_head;
    logic    w_push;
    logic    w_pop;
    t_q_stat w_q_stat;

    cltok_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_desc   (w_desc)
    );

    cltok_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_desc   (w_desc),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_q_stat (w_q_stat)
    );

    cltok_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (w_head),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_out    (o_out)
    );

`include "command_line_tokenizer_unit_assert.svh"

    `CLTOK_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, w_push, !w_q_stat.full, "push into full queue")
    `CLTOK_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, w_pop, !w_q_stat.empty, "pop from empty queue")
    `CLTOK_ASSERT_SAME(a_one_kind, i_clk, i_rst_n, o_out.valid, $onehot({o_out.byte_valid, o_out.token_end, o_out.run_overflow}), "result carries not exactly one kind")
    `CLTOK_ASSERT_NEXT(a_burst_no_gap, i_clk, i_rst_n, o_out.valid && o_out.ready && !o_out.last_of_run, o_out.valid, "gap inside a result burst")

endmodule

>>> tb/command_line_tokenizer_unit_checker.sv
// ============================================================================
// Command line tokenizer checker
// Watches the character and result channels, keeps its own model of the
// tokenizer state, predicts the results of each accepted character and
// compares every accepted result with the oldest prediction.
// ============================================================================
`timescale 1ns / 1ps

module command_line_tokenizer_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    cltok_in_if  i_in,
    cltok_out_if i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_results,
    output int   o_token_ends,
    output int   o_overflows
);
    import cltok_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       ch_ok;
        logic       tok_end;
        logic       ovf;
        logic       tail;
    } t_token_beat;

    t_token_beat      due_beats[$];
    t_token_beat      want;
    t_mode            mode;
    logic [RUN_W-1:0] run_len;
    logic [7:0]       held_ch;
    logic             held_ok;
    logic             first_done;
    int               fails;
    int               results;
    int               token_ends;
    int               overflows;
    int               diffs;

    function automatic void add_beat(logic [7:0] c, logic ok, logic te, logic ov);
        t_token_beat beat;
        beat      = t_token_beat'{c, ok, te, ov, 1'b0};
        due_beats = {due_beats, beat};
    endfunction

    function automatic void put_ch(logic [7:0] c);
        add_beat(c, 1'b1, 1'b0, 1'b0);
    endfunction

    function automatic void put_slashes(int unsigned n);
        for (int i = 0; i < n; i++) put_ch(CH_BSLASH);
    endfunction

    function automatic void end_token();
        add_beat(8'h00, 1'b0, 1'b1, 1'b0);
        first_done = 1'b1;
    endfunction

    function automatic void clear_state();
        mode       = MODE_PLAIN;
        run_len    = '0;
        held_ch    = 8'h00;
        held_ok    = 1'b0;
        first_done = 1'b0;
    endfunction

    function automatic void plain_char(logic [7:0] c);
        case (c)
            CH_TAB, CH_SPACE: if (!first_done) end_token();
            CH_COMMA:         end_token();
            CH_BSLASH:        run_len = RUN_W'(1);
            CH_QUOTE:         mode = MODE_QUOTED;
            default:          put_ch(c);
        endcase
    endfunction

    function automatic void quoted_char(logic [7:0] c);
        case (c)
            CH_BSLASH: run_len = RUN_W'(1);
            CH_QUOTE:  mode = MODE_PLAIN;
            CH_LBRACE: begin
                mode = MODE_FORMAT;
                put_ch(c);
            end
            default:   put_ch(c);
        endcase
    endfunction

    // Inside braces a closing brace or a backslash waits for the next character.
    function automatic void format_char(logic [7:0] c);
        if (c == CH_RBRACE || c == CH_BSLASH) begin
            held_ch = c;
            held_ok = 1'b1;
        end else begin
            put_ch(c);
        end
    endfunction

    function automatic void tokenize_char(logic [7:0] c, logic eoc);
        int unsigned n;
        int          first;
        logic [7:0]  h;
        first = due_beats.size();
        if (held_ok) begin
            h       = held_ch;
            held_ok = 1'b0;
            held_ch = 8'h00;
            if (h == CH_RBRACE) begin
                put_ch(h);
                if (c == CH_RBRACE) begin
                    put_ch(c);
                end else begin
                    mode = MODE_QUOTED;
                    quoted_char(c);
                end
            end else if (c == CH_QUOTE || c == CH_BSLASH) begin
                put_ch(c);
            end else begin
                put_ch(h);
                format_char(c);
            end
        end else if (run_len != 0 && c == CH_BSLASH) begin
            // A saturated run drops the backslash and only raises the flag.
            if (run_len < MAX_RUN) run_len++;
            else add_beat(8'h00, 1'b0, 1'b0, 1'b1);
        end else if (run_len != 0) begin
            n       = run_len;
            run_len = '0;
            if (mode == MODE_QUOTED) begin
                if (c == CH_LBRACE) begin
                    put_slashes(n / 2);
                    put_ch(c);
                    if (!n[0]) mode = MODE_FORMAT;
                end else if (c == CH_QUOTE) begin
                    put_slashes(n / 2);
                    if (n[0]) put_ch(c);
                    else mode = MODE_PLAIN;
                end else begin
                    put_slashes(n);
                    quoted_char(c);
                end
            end else if (c == CH_QUOTE) begin
                put_slashes(n / 2);
                if (n[0]) put_ch(c);
                else mode = MODE_QUOTED;
            end else begin
                put_slashes(n / 2 * 2);
                if (!n[0]) plain_char(c);
                else if (c == CH_SPACE || c == CH_TAB) put_ch(CH_SPACE);
                else if (c == CH_COMMA) put_ch(c);
                else begin
                    put_ch(CH_BSLASH);
                    put_ch(c);
                end
            end
        end else begin
            case (mode)
                MODE_QUOTED: quoted_char(c);
                MODE_FORMAT: format_char(c);
                default:     plain_char(c);
            endcase
        end
        if (eoc) begin
            put_slashes(run_len);
            if (held_ok) put_ch(held_ch);
            end_token();
            clear_state();
        end
        if (due_beats.size() > first) due_beats[due_beats.size() - 1].tail = 1'b1;
    endfunction

    function automatic int field_differs(string name, logic [7:0] exp_v, logic [7:0] act_v);
        if (act_v === exp_v) return 0;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_v, act_v);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
            due_beats.delete();
        end else begin
            if (i_in.valid === 1'b1 && i_in.ready === 1'b1)
                tokenize_char(i_in.in_byte, i_in.end_of_command);
            if (i_out.valid === 1'b1 && i_out.ready === 1'b1) begin
                results++;
                if (i_out.token_end === 1'b1) token_ends++;
                if (i_out.run_overflow === 1'b1) overflows++;
                if (due_beats.size() == 0) begin
                    $display("%0t: result with nothing expected, byte 0x%0h valid %0b end %0b",
                             $time, i_out.out_byte, i_out.byte_valid, i_out.token_end);
                    fails++;
                end else begin
                    want  = due_beats.pop_front();
                    diffs = field_differs("out_byte", want.ch, i_out.out_byte)
                          + field_differs("byte_valid", want.ch_ok, i_out.byte_valid)
                          + field_differs("token_end", want.tok_end, i_out.token_end)
                          + field_differs("run_overflow", want.ovf, i_out.run_overflow)
                          + field_differs("last_of_run", want.tail, i_out.last_of_run);
                    if (diffs != 0) fails++;
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= due_beats.size();
        o_results    <= results;
        o_token_ends <= token_ends;
        o_overflows  <= overflows;
    end

endmodule

>>> tb/command_line_tokenizer_unit_test.sv
// ============================================================================
// Command line tokenizer testbench
// Drives directed and random command strings into the tokenizer with random
// gaps on both channels, long output hold-offs and full drains, and takes
// the verdict from the checker's failure and pending counts.
// ============================================================================
`timescale 1ns / 1ps

module command_line_tokenizer_unit_test;
    import cltok_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_CHARS  = 95;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cltok_in_if  in_ch ();
    cltok_out_if out_ch ();

    logic [7:0] cmd_chars[$];
    int         src_idle_pct;
    int         snk_idle_pct;
    int         hold_reqs;
    int         holds_done;
    int         sent_chars;
    int         commands;
    int         quiet_cycles;
    int         fail_count;
    int         pending;
    int         results;
    int         token_ends;
    int         overflows;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    command_line_tokenizer_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    command_line_tokenizer_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results),
        .o_token_ends (token_ends),
        .o_overflows  (overflows)
    );

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != hold_reqs) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                holds_done++;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_char(input logic [7:0] c, input logic eoc);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.in_byte        <= c;
        in_ch.end_of_command <= eoc;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        sent_chars++;
        if (eoc) commands++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_cmd();
        for (int i = 0; i < cmd_chars.size(); i++)
            send_char(cmd_chars[i], i == cmd_chars.size() - 1);
        cmd_chars.delete();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    function automatic void add_char(logic [7:0] c);
        cmd_chars = {cmd_chars, c};
    endfunction

    function automatic logic [7:0] pick_char();
        case ($urandom_range(15))
            0, 1:    return CH_BSLASH;
            2:       return CH_QUOTE;
            3:       return CH_LBRACE;
            4:       return CH_RBRACE;
            5:       return CH_COMMA;
            6:       return CH_TAB;
            7:       return CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic void push_word();
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(3) == 0) add_char(8'($urandom_range(255)));
            else add_char(8'($urandom_range(8'h61, 8'h7A)));
        end
    endfunction

    function automatic void push_separator();
        case ($urandom_range(2))
            0:       add_char(CH_SPACE);
            1:       add_char(CH_TAB);
            default: add_char(CH_COMMA);
        endcase
    endfunction

    // Mostly short runs; now and then one long enough to saturate.
    function automatic void push_run();
        int n;
        if ($urandom_range(11) == 0) n = $urandom_range(MAX_RUN - 2, MAX_RUN + 4);
        else n = $urandom_range(1, 4);
        repeat (n) add_char(CH_BSLASH);
        case ($urandom_range(6))
            0:       add_char(CH_QUOTE);
            1:       add_char(CH_SPACE);
            2:       add_char(CH_TAB);
            3:       add_char(CH_COMMA);
            4:       add_char(CH_LBRACE);
            5:       add_char(8'($urandom_range(8'h61, 8'h7A)));
            default: ;
        endcase
    endfunction

    function automatic void push_quoted();
        add_char(CH_QUOTE);
        push_word();
        if ($urandom_range(1) == 0) begin
            add_char(CH_LBRACE);
            repeat ($urandom_range(0, 3)) begin
                case ($urandom_range(3))
                    0: begin
                        add_char(CH_RBRACE);
                        add_char(CH_RBRACE);
                    end
                    1: begin
                        add_char(CH_BSLASH);
                        add_char(CH_QUOTE);
                    end
                    2: begin
                        add_char(CH_BSLASH);
                        add_char(8'($urandom_range(8'h61, 8'h7A)));
                    end
                    default: push_word();
                endcase
            end
            add_char(CH_RBRACE);
        end
        if ($urandom_range(2) == 0) push_run();
        push_word();
        // An unterminated quote is left open now and then.
        if ($urandom_range(3) != 0) add_char(CH_QUOTE);
    endfunction

    task automatic send_random_command();
        cmd_chars.delete();
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(9))
                0, 1:    push_word();
                2, 3:    push_run();
                4, 5, 6: push_quoted();
                7:       repeat ($urandom_range(1, 6)) add_char(pick_char());
                default: push_separator();
            endcase
            if ($urandom_range(2) == 0) push_separator();
        end
        send_cmd();
    endtask

    // The receiver holds off while a saturated run and more commands go in,
    // so the descriptor queue fills and the input stalls; then everything drains.
    task automatic squeeze_output();
        hold_reqs++;
        repeat (MAX_RUN + 4) add_char(CH_BSLASH);
        send_cmd();
        repeat (6) send_random_command();
        wait_drained();
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.in_byte        = 8'h00;
        in_ch.end_of_command = 1'b0;
        src_idle_pct         = 19;
        snk_idle_pct         = 82;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text(" a\t,");
        send_text("\"{}}\\\"}\\");
        send_text("\"{}");
        send_text("\"{\\");
        send_text("\\\\\"\\\\");
        send_text("\\ ");

        squeeze_output();
        while (sent_chars < PHASE_CHARS) send_random_command();
        wait_drained();

        src_idle_pct = 82;
        snk_idle_pct = 19;
        while (sent_chars < 2 * PHASE_CHARS) send_random_command();
        wait_drained();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        squeeze_output();
        while (sent_chars < 3 * PHASE_CHARS) send_random_command();
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Sent %0d characters in %0d commands under three idle mixes and two hold-offs.",
                 sent_chars, commands);
        $display("Checked %0d results: %0d token ends, %0d run overflow flags.",
                 results, token_ends, overflows);
        if (fail_count == 0 && pending == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
